@@ hw/rtl/mdfe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdfe_pkg
// Shared constants, marker tables and the result word type of the
// marker-delimited frame extractor.
// ----------------------------------------------------------------------------
package mdfe_pkg;

  localparam int START_LEN = 32;
  localparam int END_LEN   = 40;

  localparam int POS_W    = 6;
  localparam int COUNT_W  = 17;
  localparam int TICK_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int ACTION_W = 2;
  localparam int PHASE_W  = 2;

  localparam int                  DEF_COUNT_LIMIT   = 131071;
  localparam logic [TICK_W-1:0]   DEF_TIMEOUT_TICKS = 16'd12000;
  localparam logic [TICK_W-1:0]   TICK_MAX          = 16'hFFFF;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_START = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_BYTE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd2;

  // Capture phase codes
  localparam logic [PHASE_W-1:0]  PH_HUNT    = 2'd0;
  localparam logic [PHASE_W-1:0]  PH_FRAME   = 2'd1;
  localparam logic [PHASE_W-1:0]  PH_DONE    = 2'd2;
  localparam logic [PHASE_W-1:0]  PH_TIMEOUT = 2'd3;

  // Character 0 of each marker sits at index 0
  localparam logic [0:START_LEN-1][BYTE_W-1:0] START_MARKER =
    "3d99de816e5ad7742b61a37c39141783";
  localparam logic [0:END_LEN-1][BYTE_W-1:0] END_MARKER =
    "f681a5c52351befe0e3524eb1a40f14b7803317a";

  typedef struct packed {
    logic                 store_valid;
    logic [BYTE_W-1:0]    store_byte;
    logic                 frame_done;
    logic [COUNT_W-1:0]   frame_length;
    logic                 timed_out;
    logic [PHASE_W-1:0]   capture_status;
  } mdfe_result_t;

  function automatic logic start_hit(input logic [POS_W-1:0] pos,
                                     input logic [BYTE_W-1:0] b);
    logic hit;
    hit = 1'b0;
    if (pos < POS_W'(START_LEN)) begin
      hit = (START_MARKER[pos[4:0]] == b);
    end
    return hit;
  endfunction

  function automatic logic end_hit(input logic [POS_W-1:0] pos,
                                   input logic [BYTE_W-1:0] b);
    logic hit;
    hit = 1'b0;
    if (pos < POS_W'(END_LEN)) begin
      hit = (END_MARKER[pos] == b);
    end
    return hit;
  endfunction

endpackage

@@ hw/rtl/marker_delimited_frame_extractor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marker_delimited_frame_extractor
// Hunts a fixed start marker in a byte stream, passes frame bytes out for
// storage until a fixed end marker, and stops a capture on a tick timeout.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_action, in_rx_byte
//   out      output     out_valid/out_stall  store, frame, timeout, status
//   cfg      input      cfg_valid/cfg_ready  cfg_data (timeout_ticks)
//
// One word per cycle sustained while out_stall is low; an accepted word is
// held in the input register, goes through one pass of compare and count
// logic into the result register and leaves from there.
// rst_n is synchronous and active low; it clears the capture to hunting,
// empties both registers and loads a timeout of 12000 ticks.
// A stall on the out side holds the result register and then the input
// register; capture state advances only when a word moves into the result.
// ----------------------------------------------------------------------------
module marker_delimited_frame_extractor import mdfe_pkg::*; #(
  parameter int COUNT_LIMIT = DEF_COUNT_LIMIT
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [BYTE_W-1:0]   in_rx_byte,

  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_store_valid,
  output logic [BYTE_W-1:0]   out_store_byte,
  output logic                out_frame_done,
  output logic [COUNT_W-1:0]  out_frame_length,
  output logic                out_timed_out,
  output logic [PHASE_W-1:0]  out_capture_status,

  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [TICK_W-1:0]   cfg_data
);

  logic                in_vld_r, in_vld_nxt;
  logic [ACTION_W-1:0] in_action_r;
  logic [BYTE_W-1:0]   in_byte_r;
  logic [TICK_W-1:0]   timeout_r;

  logic                res_free;
  logic                advance;
  logic                in_take;
  mdfe_result_t        step_res;
  mdfe_result_t        out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= DEF_TIMEOUT_TICKS;
    end else if (cfg_valid && cfg_ready) begin
      timeout_r <= cfg_data;
    end
  end

  // move the held word into the result register whenever it has room
  assign advance    = in_vld_r && res_free;
  assign in_stall   = in_vld_r && !res_free;
  assign in_take    = in_valid && !in_stall;
  assign in_vld_nxt = in_take || (in_vld_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_action_r <= in_action;
      in_byte_r   <= in_rx_byte;
    end
  end

  mdfe_step #(
    .COUNT_LIMIT (COUNT_LIMIT)
  ) u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (advance),
    .action        (in_action_r),
    .rx_byte       (in_byte_r),
    .timeout_ticks (timeout_r),
    .result        (step_res)
  );

  mdfe_res_reg u_res (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .load_data (step_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .free      (res_free),
    .out_data  (out_res)
  );

  assign out_store_valid    = out_res.store_valid;
  assign out_store_byte     = out_res.store_byte;
  assign out_frame_done     = out_res.frame_done;
  assign out_frame_length   = out_res.frame_length;
  assign out_timed_out      = out_res.timed_out;
  assign out_capture_status = out_res.capture_status;

`ifndef SYNTH
  a_done_is_stored: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> (out_store_valid && out_capture_status == PH_DONE))
    else $error("frame end without stored byte or finished status");

  a_timeout_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_timed_out) |-> (out_capture_status == PH_TIMEOUT && !out_store_valid))
    else $error("timeout result with wrong status");

  a_length_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_frame_done) |-> (out_frame_length == '0))
    else $error("frame length outside frame end");

  a_held_word_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !advance) |=> (in_vld_r && $stable(in_action_r) && $stable(in_byte_r)))
    else $error("held input word lost or changed");
`endif

endmodule

@@ hw/rtl/mdfe_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdfe_step
// Capture state registers and the single-pass next-state and result logic
// for one word.
// ----------------------------------------------------------------------------
module mdfe_step import mdfe_pkg::*; #(
  parameter int COUNT_LIMIT = DEF_COUNT_LIMIT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [ACTION_W-1:0] action,
  input  logic [BYTE_W-1:0]   rx_byte,
  input  logic [TICK_W-1:0]   timeout_ticks,
  output mdfe_result_t        result
);

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [TICK_W-1:0]  ticks_r, ticks_nxt;

  logic [COUNT_W:0]   cnt_inc;
  logic [POS_W-1:0]   pos_inc;
  logic [TICK_W-1:0]  ticks_inc;

  assign cnt_inc   = {1'b0, cnt_r} + 1'b1;
  assign pos_inc   = pos_r + 1'b1;
  assign ticks_inc = (ticks_r < TICK_MAX) ? ticks_r + 1'b1 : ticks_r;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    ticks_nxt = ticks_r;
    result    = '0;

    case (action)
      ACT_START: begin
        phase_nxt = PH_HUNT;
        pos_nxt   = '0;
        cnt_nxt   = '0;
        ticks_nxt = '0;
      end
      ACT_BYTE: begin
        if (phase_r == PH_HUNT) begin
          if (start_hit(pos_r, rx_byte)) begin
            if (pos_inc >= POS_W'(START_LEN)) begin
              pos_nxt   = '0;
              phase_nxt = PH_FRAME;
            end else begin
              pos_nxt = pos_inc;
            end
          end else begin
            pos_nxt = '0;
          end
        end else if (phase_r == PH_FRAME) begin
          result.store_valid = 1'b1;
          result.store_byte  = rx_byte;
          // wrap past the limit; a completed frame clears it anyway
          cnt_nxt = (cnt_inc > (COUNT_W+1)'(COUNT_LIMIT)) ? '0 : cnt_inc[COUNT_W-1:0];
          if (end_hit(pos_r, rx_byte)) begin
            if (pos_inc >= POS_W'(END_LEN)) begin
              result.frame_done   = 1'b1;
              result.frame_length = (cnt_inc > (COUNT_W+1)'(END_LEN)) ?
                                    COUNT_W'(cnt_inc - (COUNT_W+1)'(END_LEN)) : '0;
              phase_nxt = PH_DONE;
              pos_nxt   = '0;
              cnt_nxt   = '0;
            end else begin
              pos_nxt = pos_inc;
            end
          end else begin
            pos_nxt = '0;
          end
        end
      end
      ACT_TICK: begin
        if (phase_r == PH_HUNT || phase_r == PH_FRAME) begin
          ticks_nxt = ticks_inc;
          if (ticks_inc >= timeout_ticks) begin
            phase_nxt        = PH_TIMEOUT;
            result.timed_out = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    result.capture_status = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pos_r   <= '0;
      cnt_r   <= '0;
      ticks_r <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
      ticks_r <= ticks_nxt;
    end
  end

endmodule

@@ hw/rtl/mdfe_res_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdfe_res_reg
// Result register: holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module mdfe_res_reg import mdfe_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  mdfe_result_t load_data,
  input  logic         out_stall,
  output logic         out_valid,
  output logic         free,
  output mdfe_result_t out_data
);

  logic         vld_r, vld_nxt;
  mdfe_result_t data_r;

  // register is free when empty or being drained this cycle
  assign free    = !vld_r || !out_stall;
  assign vld_nxt = load || (vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule
